>>> rtl/core/octave_value_noise_2d_defines.svh
// assertion helpers shared by the noise core
`ifndef OCTAVE_VALUE_NOISE_2D_DEFINES_SVH
`define OCTAVE_VALUE_NOISE_2D_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OVN_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define OVN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/ovn_pkg.sv
package ovn_pkg;

  localparam int MAX_OCTAVES = 16;
  localparam int NUM_OCT     = MAX_OCTAVES - 1;
  localparam int SH_W        = $clog2(MAX_OCTAVES);
  localparam int SC_W        = 32 + MAX_OCTAVES;
  localparam int CORNER_W    = 23;
  localparam int FRAC_W      = 18;
  localparam int I_W         = 24;
  localparam int DI_W        = 25;
  localparam int OCT_W       = 26;
  localparam int AMP_W       = 33;
  localparam int TERM_W      = 44;
  localparam int ACC_W       = 32;
  localparam int OCNT_W      = 5;
  localparam int CFG_IDX_W   = 4;
  localparam int OCT_LAT     = 10;
  localparam int PIPE_D      = OCT_LAT + 1 + NUM_OCT + 1;

  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD   = 32'd789221;
  localparam logic [31:0] HASH_OFS   = 32'd1376312589;
  localparam logic [31:0] HASH_ROW   = 32'd57;
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
  localparam logic [AMP_W-1:0] AMP_CAP = {1'b1, 32'd0};
  localparam logic [15:0] OUT_MAX    = 16'd64225;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSISTENCE  = 4'd0,
    CFG_OCTAVE_COUNT = 4'd1,
    CFG_SEED_MULT    = 4'd2,
    CFG_TURBULENCE   = 4'd3
  } cfg_reg_t;

endpackage

>>> rtl/core/ovn_octave.sv
module ovn_octave
  import ovn_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [SH_W-1:0]         shift_amt,
  input  logic signed [31:0]      x_coord,
  input  logic signed [31:0]      y_coord,
  input  logic [31:0]             seed_ofs,
  input  logic [19:0]             turbulence,
  output logic signed [OCT_W-1:0] oct_val
);

  // split: integer part toward zero, signed fraction
  logic [31:0]              ix, iy;
  logic signed [FRAC_W-1:0] fx, fy;

  always_comb begin
    logic signed [SC_W-1:0] sx, sy, flx, fly;
    logic ax, ay;
    sx  = SC_W'(x_coord) <<< shift_amt;
    sy  = SC_W'(y_coord) <<< shift_amt;
    flx = sx >>> 16;
    fly = sy >>> 16;
    ax  = sx[SC_W-1] && (sx[15:0] != 16'd0);
    ay  = sy[SC_W-1] && (sy[15:0] != 16'd0);
    ix  = flx[31:0] + 32'(ax);
    iy  = fly[31:0] + 32'(ay);
    fx  = ax ? $signed({2'b11, sx[15:0]}) : $signed({2'b00, sx[15:0]});
    fy  = ay ? $signed({2'b11, sy[15:0]}) : $signed({2'b00, sy[15:0]});
  end

  logic [31:0]              ix_r, iy_r;
  logic signed [FRAC_W-1:0] fx_r [OCT_LAT];
  logic signed [FRAC_W-1:0] fy_r [OCT_LAT];

  logic [31:0] n_nxt [4];
  logic [31:0] n_r   [4];
  logic [31:0] n2_r  [4];
  logic [31:0] nb_r  [4];
  logic [31:0] t_r   [4];
  logic [31:0] nc_r  [4];
  logic [30:0] v_r   [4];
  logic signed [CORNER_W-1:0] c_r [4];

  always_comb begin
    logic [31:0] cx, cy, m;
    for (int k = 0; k < 4; k++) begin
      cx = ix_r + 32'(k % 2);
      cy = iy_r + 32'(k / 2);
      m  = cx + cy * HASH_ROW;
      n_nxt[k] = (m << 13) ^ m;
    end
  end

  logic signed [I_W-1:0]   px1_r, px2_r, c1_r, c3_r, i1_r, i2_r, i1b_r;
  logic signed [OCT_W-1:0] py_r, oct_r;

  always_ff @(posedge clk) begin
    logic signed [I_W-1:0]  d1, d2;
    logic signed [DI_W-1:0] dy;
    logic [50:0]            tp;
    if (en) begin
      ix_r <= ix;
      iy_r <= iy;
      fx_r[0] <= fx;
      fy_r[0] <= fy;
      for (int s = 1; s < OCT_LAT; s++) begin
        fx_r[s] <= fx_r[s-1];
        fy_r[s] <= fy_r[s-1];
      end
      for (int k = 0; k < 4; k++) begin
        n_r[k]  <= n_nxt[k];
        n2_r[k] <= n_r[k] * n_r[k];
        nb_r[k] <= n_r[k];
        t_r[k]  <= n2_r[k] * HASH_MUL_A + HASH_ADD;
        nc_r[k] <= nb_r[k];
        v_r[k]  <= 31'(nc_r[k] * t_r[k] + seed_ofs);
        tp      = 51'(v_r[k]) * 51'(turbulence);
        c_r[k]  <= CORNER_W'(65536) - $signed({2'b00, tp[50:30]});
      end
      // blend along x
      d1 = I_W'(c_r[1]) - I_W'(c_r[0]);
      d2 = I_W'(c_r[3]) - I_W'(c_r[2]);
      px1_r <= I_W'((42'(d1) * 42'(fx_r[5])) >>> 16);
      px2_r <= I_W'((42'(d2) * 42'(fx_r[5])) >>> 16);
      c1_r  <= I_W'(c_r[0]);
      c3_r  <= I_W'(c_r[2]);
      i1_r  <= c1_r + px1_r;
      i2_r  <= c3_r + px2_r;
      // blend along y
      dy = DI_W'(i2_r) - DI_W'(i1_r);
      py_r  <= OCT_W'((43'(dy) * 43'(fy_r[7])) >>> 16);
      i1b_r <= i1_r;
      oct_r <= OCT_W'(i1b_r) + py_r;
    end
  end

  assign oct_val = oct_r;

endmodule

>>> rtl/core/octave_value_noise_2d.sv
// Fractal 2D value noise: one sample point (signed Q16.16 x and y) in, one noise level
// (unsigned Q0.16, clamped to 0..0.98) out. Every octave has its own hash and blend
// pipeline, so a new word is taken in every cycle while in_stall is low. The stages are,
// in order, the per-octave hash and bilinear blend, the amplitude weighting, the chain
// of saturating accumulator adds (one octave per stage) and the output register. The
// whole pipeline freezes while a finished word waits under out_stall, and empty stages
// still move forward otherwise. Configuration is taken on any cycle (cfg_ready is always
// high) but must only be written while no word is in flight; the per-octave amplitudes
// form a chain that has to settle, so after reset and after every configuration write
// in_stall stays high while the chain settles.
`include "octave_value_noise_2d_defines.svh"

module octave_value_noise_2d
  import ovn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_noise_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers
  logic [17:0]       persistence_r;
  logic [OCNT_W-1:0] octave_count_r;
  logic [31:0]       seed_mult_r;
  logic [19:0]       turbulence_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persistence_r  <= 18'd32768;
      octave_count_r <= OCNT_W'(5);
      seed_mult_r    <= 32'd1;
      turbulence_r   <= 20'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PERSISTENCE:  persistence_r  <= cfg_data[17:0];
        CFG_OCTAVE_COUNT: octave_count_r <= cfg_data[OCNT_W-1:0];
        CFG_SEED_MULT:    seed_mult_r    <= cfg_data;
        CFG_TURBULENCE:   turbulence_r   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // settling window for the amplitude chain after reset or a write
  logic [SH_W-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SH_W'(NUM_OCT);
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= SH_W'(NUM_OCT);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SH_W'(1);
    end
  end

  // values derived from configuration, recomputed every cycle
  logic [31:0]       seed_ofs_r;
  logic [OCNT_W-1:0] count_r;
  logic [AMP_W-1:0]  amp_r   [NUM_OCT];
  logic [AMP_W-1:0]  amp_nxt [NUM_OCT];

  always_comb begin
    logic [50:0] prod;
    amp_nxt[0] = AMP_ONE;
    for (int i = 1; i < NUM_OCT; i++) begin
      prod = 51'(amp_r[i-1]) * 51'(persistence_r);
      // amplitude saturates at 2^32
      amp_nxt[i] = (prod[50:16] > 35'(AMP_CAP)) ? AMP_CAP : prod[48:16];
    end
  end

  always_ff @(posedge clk) begin
    seed_ofs_r <= HASH_OFS * seed_mult_r;
    // octaves summed: setting minus one (zero for a setting of zero), setting capped at the octave limit
    if (octave_count_r == '0) begin
      count_r <= '0;
    end else if (octave_count_r > OCNT_W'(MAX_OCTAVES)) begin
      count_r <= OCNT_W'(NUM_OCT);
    end else begin
      count_r <= octave_count_r - OCNT_W'(1);
    end
    for (int i = 0; i < NUM_OCT; i++) begin
      amp_r[i] <= amp_nxt[i];
    end
  end

  // pipeline advance: hold everything while the output word is refused
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || (settle_r != '0);

  logic [PIPE_D-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_D-2:0], in_valid && (settle_r == '0)};
    end
  end

  assign out_valid = vld_r[PIPE_D-1];

  // one hash and blend pipeline per octave
  logic signed [OCT_W-1:0] oct_val [NUM_OCT];

  for (genvar g = 0; g < NUM_OCT; g++) begin : g_oct
    ovn_octave u_oct (
      .clk        (clk),
      .en         (adv),
      .shift_amt  (SH_W'(g)),
      .x_coord    (in_x_coord),
      .y_coord    (in_y_coord),
      .seed_ofs   (seed_ofs_r),
      .turbulence (turbulence_r),
      .oct_val    (oct_val[g])
    );
  end

  // amplitude weighting, unused octaves forced to zero
  logic signed [TERM_W-1:0] term_r [NUM_OCT];

  always_ff @(posedge clk) begin
    logic signed [59:0] wp;
    if (adv) begin
      for (int i = 0; i < NUM_OCT; i++) begin
        wp = 60'(oct_val[i]) * 60'($signed({1'b0, amp_r[i]}));
        term_r[i] <= (OCNT_W'(i) < count_r) ? TERM_W'(wp >>> 16) : '0;
      end
    end
  end

  // accumulator chain, one saturating add per stage
  logic signed [ACC_W-1:0]  acc_r  [NUM_OCT];
  logic signed [TERM_W-1:0] tcar_r [NUM_OCT][NUM_OCT];

  for (genvar k = 0; k < NUM_OCT; k++) begin : g_acc
    logic signed [ACC_W-1:0]  acc_in;
    logic signed [TERM_W-1:0] terms_in [NUM_OCT];
    logic signed [ACC_W-1:0]  acc_nxt;
    logic signed [TERM_W:0]   sum;

    if (k == 0) begin : g_first
      assign acc_in   = '0;
      assign terms_in = term_r;
    end else begin : g_rest
      assign acc_in   = acc_r[k-1];
      assign terms_in = tcar_r[k-1];
    end

    always_comb begin
      sum = (TERM_W+1)'(acc_in) + (TERM_W+1)'(terms_in[k]);
      if (sum > (TERM_W+1)'(32'sh7fff_ffff)) begin
        acc_nxt = 32'sh7fff_ffff;
      end else if (sum < -((TERM_W+1)'(33'sh0_8000_0000))) begin
        acc_nxt = 32'sh8000_0000;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[k]  <= acc_nxt;
        tcar_r[k] <= terms_in;
      end
    end
  end

  // (s + 1) / 2 with floor, clamped to 0..0.98
  logic [15:0] level_r;

  always_ff @(posedge clk) begin
    logic signed [ACC_W+1:0] half;
    if (adv) begin
      half = ((ACC_W+2)'(acc_r[NUM_OCT-1]) + (ACC_W+2)'(65536)) >>> 1;
      if (half < 0) begin
        level_r <= 16'd0;
      end else if (half > (ACC_W+2)'(OUT_MAX)) begin
        level_r <= OUT_MAX;
      end else begin
        level_r <= half[15:0];
      end
    end
  end

  assign out_noise_level = level_r;

  `OVN_ASSERT_NOW(a_level_range, out_valid, out_noise_level <= OUT_MAX, "noise level above clamp")
  `OVN_ASSERT_NEXT(a_last_to_out, adv && vld_r[PIPE_D-2], out_valid, "finished word lost")
  `OVN_ASSERT_NOW(a_count_limit, 1'b1, count_r <= OCNT_W'(NUM_OCT), "octave count above limit")
  `OVN_ASSERT_NOW(a_amp_cap, settle_r == '0, amp_r[NUM_OCT-1] <= AMP_CAP, "amplitude above cap")

endmodule
